/* design/header_csv_tokenizer_macros.svh */
// ----------------------------------------------------------------------------
// header_csv_tokenizer_macros
// assertion macros used by the tokenizer rtl, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef HEADER_CSV_TOKENIZER_MACROS_SVH
`define HEADER_CSV_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HCT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hct assertion failed");

// next-cycle implication
`define HCT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hct assertion failed");

`else

`define HCT_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define HCT_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* design/hct_pkg.sv */
// ----------------------------------------------------------------------------
// hct_pkg
// constants, register codes and beat type of the header value tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hct_pkg;

    // default longest value, in bytes
    localparam int MAX_VALUE_LEN = 4096;

    // running token index width
    localparam int IDX_W = 16;

    // byte codes
    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] BSLASH_BYTE = 8'h5C;
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] TAB_BYTE    = 8'h09;

    // register defaults
    localparam logic [7:0] SEPARATOR_RESET  = 8'd44;
    localparam logic       TRACK_DUPS_RESET = 1'b1;

    // register map, index taken from paddr[2]
    localparam int APB_ADDR_W = 3;
    localparam logic REG_SEPARATOR  = 1'b0;
    localparam logic REG_TRACK_DUPS = 1'b1;

    // one input beat
    typedef struct packed {
        logic [7:0] value_byte;
        logic       first_of_value;
        logic       is_duplicate;
        logic       last_of_value;
    } in_beat_t;

endpackage

/* design/header_csv_tokenizer.sv */
// a beat is held in the input register, and its result is then held in the result register
// throughput: one byte per cycle while results are taken, per-byte state loop in hct_core
// beats that give no result pass through without using the output register
// reset: asynchronous, clears tokenizer state and both beat valid flags,
// and loads separator 44 and track_dups 1
// ----------------------------------------------------------------------------
// header_csv_tokenizer
// splits header field values into comma-list tokens, one byte per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "header_csv_tokenizer_macros.svh"

module header_csv_tokenizer #(
    parameter int MAX_VALUE_LEN = hct_pkg::MAX_VALUE_LEN,
    localparam int OFF_W = $clog2(MAX_VALUE_LEN),
    localparam int LEN_W = OFF_W + 1,
    localparam int FLD_W = OFF_W + LEN_W + hct_pkg::IDX_W,
    localparam int TDATA_W = ((FLD_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // value_byte
    input  logic [1:0]                    s_tuser,  // first_of_value, is_duplicate
    input  logic                          s_tlast,  // last_of_value
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata,  // token_start, token_length,
                                                    // token_index, zero pad
    output logic [1:0]                    m_tuser,  // token_valid, too_long
    output logic                          m_tlast,  // end_of_value
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hct_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // configuration registers
    logic [7:0] separator_reg;
    logic       track_dups_reg;
    logic       cfg_write;
    logic       reg_sel;

    // input register
    logic              in_valid_reg;
    hct_pkg::in_beat_t in_beat_reg;
    logic              advance;
    logic              out_free;

    // core result
    logic                      emit;
    logic                      token_valid;
    logic [OFF_W-1:0]          token_start;
    logic [LEN_W-1:0]          token_length;
    logic [hct_pkg::IDX_W-1:0] token_index;
    logic                      end_of_value;
    logic                      too_long;

    // result register
    logic                 out_valid_reg;
    logic [TDATA_W-1:0]   out_data_reg;
    logic [1:0]           out_user_reg;
    logic                 out_last_reg;

    // apb register file
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg  <= hct_pkg::SEPARATOR_RESET;
            track_dups_reg <= hct_pkg::TRACK_DUPS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                hct_pkg::REG_SEPARATOR:  separator_reg  <= pwdata[7:0];
                hct_pkg::REG_TRACK_DUPS: track_dups_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            hct_pkg::REG_SEPARATOR:  prdata = {24'd0, separator_reg};
            hct_pkg::REG_TRACK_DUPS: prdata = {31'd0, track_dups_reg};
            default:                 prdata = '0;
        endcase
    end

    // handshake: a beat leaves the input register when it gives no result or its result has room
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_beat_reg.value_byte     <= s_tdata;
            in_beat_reg.first_of_value <= s_tuser[0];
            in_beat_reg.is_duplicate   <= s_tuser[1];
            in_beat_reg.last_of_value  <= s_tlast;
        end
    end

    hct_core #(
        .MAX_VALUE_LEN (MAX_VALUE_LEN)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .beat         (in_beat_reg),
        .separator    (separator_reg),
        .track_dups   (track_dups_reg),
        .emit         (emit),
        .token_valid  (token_valid),
        .token_start  (token_start),
        .token_length (token_length),
        .token_index  (token_index),
        .end_of_value (end_of_value),
        .too_long     (too_long)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance && emit;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && emit)
        begin
            out_data_reg <= TDATA_W'({token_index, token_length, token_start});
            out_user_reg <= {too_long, token_valid};
            out_last_reg <= end_of_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // a result that does not close a value always carries a token
    `HCT_ASSERT_IMPL(a_mid_result_has_token, clk, rst_n, out_valid_reg && !out_last_reg,
        out_user_reg[0])

    // a reported token is never empty
    `HCT_ASSERT_IMPL(a_token_not_empty, clk, rst_n, out_valid_reg && out_user_reg[0],
        out_data_reg[OFF_W +: LEN_W] != '0)

    // input side only stalls while a beat is held
    `HCT_ASSERT_IMPL(a_stall_needs_beat, clk, rst_n, !s_tready, in_valid_reg)

    // a held beat keeps its payload until it moves on
    `HCT_ASSERT_NEXT(a_held_beat_stable, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(in_beat_reg))

endmodule

/* design/hct_core.sv */
// ----------------------------------------------------------------------------
// hct_core
// per-byte tokenizer state and result logic for one registered beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hct_core #(
    parameter int MAX_VALUE_LEN = hct_pkg::MAX_VALUE_LEN,
    localparam int OFF_W = $clog2(MAX_VALUE_LEN),
    localparam int LEN_W = OFF_W + 1,
    localparam int POS_W = OFF_W + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  hct_pkg::in_beat_t       beat,
    input  logic [7:0]              separator,
    input  logic                    track_dups,
    output logic                    emit,
    output logic                    token_valid,
    output logic [OFF_W-1:0]        token_start,
    output logic [LEN_W-1:0]        token_length,
    output logic [hct_pkg::IDX_W-1:0] token_index,
    output logic                    end_of_value,
    output logic                    too_long
);

    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_VALUE_LEN);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(MAX_VALUE_LEN - 1);

    // state
    logic                      in_quote_reg;
    logic                      prev_bs_reg;
    logic [POS_W-1:0]          pos_reg;
    logic                      have_reg;
    logic [OFF_W-1:0]          first_ns_reg;
    logic [OFF_W-1:0]          last_ns_reg;
    logic                      first_q_reg;
    logic                      last_q_reg;
    logic [hct_pkg::IDX_W-1:0] tokens_reg;
    logic                      ignoring_reg;
    logic                      ovf_reg;

    // state after a first-byte clear
    logic                      c_inq;
    logic                      c_bs;
    logic [POS_W-1:0]          c_pos;
    logic                      c_have;
    logic [OFF_W-1:0]          c_first;
    logic [OFF_W-1:0]          c_last;
    logic                      c_fq;
    logic                      c_lq;
    logic                      c_ovf;
    logic [hct_pkg::IDX_W-1:0] tokens_base;
    logic                      ignoring_next;

    // per-byte work
    logic                      sat;
    logic [OFF_W-1:0]          off;
    logic [POS_W-1:0]          pos_next;
    logic                      ovf_next;
    logic                      is_quote;
    logic                      brk;
    logic                      inq_u;
    logic                      kept;
    logic                      have_u;
    logic [OFF_W-1:0]          first_u;
    logic [OFF_W-1:0]          last_u;
    logic                      fq_u;
    logic                      lq_u;
    logic                      closes;
    logic [LEN_W-1:0]          len0;
    logic [LEN_W-1:0]          len_a;
    logic [LEN_W-1:0]          len_b;
    logic [OFF_W-1:0]          start_a;
    logic                      tok_ok;

    // clear on first byte, then trim, quote and split
    always_comb
    begin
        tokens_base   = tokens_reg;
        ignoring_next = ignoring_reg;
        c_inq   = in_quote_reg;
        c_bs    = prev_bs_reg;
        c_pos   = pos_reg;
        c_have  = have_reg;
        c_first = first_ns_reg;
        c_last  = last_ns_reg;
        c_fq    = first_q_reg;
        c_lq    = last_q_reg;
        c_ovf   = ovf_reg;
        if (beat.first_of_value)
        begin
            if (!beat.is_duplicate)
            begin
                ignoring_next = 1'b0;
                tokens_base   = '0;
            end
            else if (!track_dups)
            begin
                ignoring_next = 1'b1;
            end
            c_inq   = 1'b0;
            c_bs    = 1'b0;
            c_pos   = '0;
            c_have  = 1'b0;
            c_first = '0;
            c_last  = '0;
            c_fq    = 1'b0;
            c_lq    = 1'b0;
            c_ovf   = 1'b0;
        end

        // offset, saturating
        sat      = (c_pos >= POS_MAX);
        off      = sat ? OFF_LAST : c_pos[OFF_W-1:0];
        pos_next = sat ? c_pos : c_pos + POS_W'(1);
        ovf_next = c_ovf | sat;

        // quote tracking, a backslash before a quote keeps the quote open
        is_quote = (beat.value_byte == hct_pkg::QUOTE_BYTE);
        brk      = !is_quote && (beat.value_byte == separator) && !c_inq;
        if (is_quote)
            inq_u = c_inq ? c_bs : 1'b1;
        else
            inq_u = c_inq;

        // extent of the trimmed token
        kept    = !brk && (beat.value_byte != hct_pkg::SPACE_BYTE)
                  && (beat.value_byte != hct_pkg::TAB_BYTE);
        have_u  = c_have | kept;
        first_u = (kept && !c_have) ? off : c_first;
        fq_u    = (kept && !c_have) ? is_quote : c_fq;
        last_u  = kept ? off : c_last;
        lq_u    = kept ? is_quote : c_lq;

        // token length after dropping one quote at each end
        closes  = brk || beat.last_of_value;
        len0    = {1'b0, last_u} - {1'b0, first_u} + LEN_W'(1);
        len_a   = fq_u ? len0 - LEN_W'(1) : len0;
        start_a = fq_u ? first_u + OFF_W'(1) : first_u;
        len_b   = ((len_a != '0) && lq_u) ? len_a - LEN_W'(1) : len_a;
        tok_ok  = !ignoring_next && closes && have_u && (len_b != '0);

        // result
        emit         = !ignoring_next && closes && (tok_ok || beat.last_of_value);
        token_valid  = tok_ok;
        token_start  = tok_ok ? start_a : '0;
        token_length = tok_ok ? len_b : '0;
        token_index  = tok_ok ? tokens_base : '0;
        end_of_value = beat.last_of_value;
        too_long     = ovf_next;
    end

    // state update per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg <= 1'b0;
            prev_bs_reg  <= 1'b0;
            pos_reg      <= '0;
            have_reg     <= 1'b0;
            first_ns_reg <= '0;
            last_ns_reg  <= '0;
            first_q_reg  <= 1'b0;
            last_q_reg   <= 1'b0;
            tokens_reg   <= '0;
            ignoring_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else if (step)
        begin
            ignoring_reg <= ignoring_next;
            tokens_reg   <= tok_ok ? tokens_base + hct_pkg::IDX_W'(1) : tokens_base;
            if (ignoring_next)
            begin
                in_quote_reg <= c_inq;
                prev_bs_reg  <= c_bs;
                pos_reg      <= c_pos;
                have_reg     <= c_have;
                first_ns_reg <= c_first;
                last_ns_reg  <= c_last;
                first_q_reg  <= c_fq;
                last_q_reg   <= c_lq;
                ovf_reg      <= c_ovf;
            end
            else if (beat.last_of_value)
            begin
                in_quote_reg <= 1'b0;
                prev_bs_reg  <= 1'b0;
                pos_reg      <= '0;
                have_reg     <= 1'b0;
                first_ns_reg <= '0;
                last_ns_reg  <= '0;
                first_q_reg  <= 1'b0;
                last_q_reg   <= 1'b0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                in_quote_reg <= closes ? 1'b0 : inq_u;
                prev_bs_reg  <= (beat.value_byte == hct_pkg::BSLASH_BYTE);
                pos_reg      <= pos_next;
                have_reg     <= closes ? 1'b0 : have_u;
                first_ns_reg <= first_u;
                last_ns_reg  <= last_u;
                first_q_reg  <= fq_u;
                last_q_reg   <= lq_u;
                ovf_reg      <= ovf_next;
            end
        end
    end

endmodule
